@@ sv/mi3_pkg.sv @@
package mi3_pkg;

    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned N_ELEM    = 9;
    localparam int unsigned DEF_FRAC  = 16;
    localparam int unsigned DET_W     = 99;
    localparam int unsigned DMAG_W    = DET_W - 1;
    localparam int unsigned Q_BITS    = 33;
    localparam int unsigned FRONT_LAT = 8;
    localparam int unsigned LAST_ST   = FRONT_LAT + 1 + Q_BITS;

    typedef logic [3:0] idx_t;

    // adjugate entry k = m[a]*m[b] - m[c]*m[d], index = row*3+col
    localparam idx_t ADJ_IDX [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              clip;
    } lane_res_t;

endpackage

@@ sv/mi3_div_lane.sv @@
module mi3_div_lane #(
    parameter int unsigned FRAC_BITS = mi3_pkg::DEF_FRAC
) (
    input  logic                        clk,
    input  logic                        ce,
    input  logic [63:0]                 amag,
    input  logic                        aneg,
    input  logic [mi3_pkg::DMAG_W-1:0]  dmag,
    input  logic [mi3_pkg::DMAG_W-1:0]  dstep [mi3_pkg::Q_BITS],
    output mi3_pkg::lane_res_t          res
);
    localparam int unsigned QB = mi3_pkg::Q_BITS;
    localparam int unsigned RW = mi3_pkg::DET_W;
    localparam int unsigned DW = mi3_pkg::DMAG_W;
    localparam int unsigned NW = 64 + 2 * FRAC_BITS;
    localparam int unsigned HW = NW - QB;

    logic [RW-1:0] r_reg   [QB+1];
    logic [QB-1:0] lo_reg  [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          ovf_reg [QB+1];
    logic          neg_reg [QB+1];

    logic [NW-1:0] num;
    logic [HW-1:0] num_hi;

    assign num    = {amag, {(2 * FRAC_BITS){1'b0}}};
    assign num_hi = num[NW-1:QB];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_reg[0]   <= {{(RW-HW){1'b0}}, num_hi};
            lo_reg[0]  <= num[QB-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= {{(DW-HW){1'b0}}, num_hi} >= dmag;
            neg_reg[0] <= aneg;
        end
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_step
        logic [RW-1:0] r_sh;
        logic [RW-1:0] d_ext;
        logic          ge;

        assign r_sh  = {r_reg[s-1][RW-2:0], lo_reg[s-1][QB-1]};
        assign d_ext = {1'b0, dstep[s-1]};
        assign ge    = r_sh >= d_ext;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                r_reg[s]   <= ge ? (r_sh - d_ext) : r_sh;
                lo_reg[s]  <= {lo_reg[s-1][QB-2:0], 1'b0};
                q_reg[s]   <= {q_reg[s-1][QB-2:0], ge};
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    logic [QB-1:0] q;
    logic          clip;

    assign q    = q_reg[QB];
    assign clip = ovf_reg[QB] ||
                  (neg_reg[QB] ? (q > {2'b01, 31'd0}) : (q > {2'b00, {31{1'b1}}}));

    always_comb
    begin
        res.clip = clip;
        if (clip)
            res.value = neg_reg[QB] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            res.value = neg_reg[QB] ? (32'd0 - q[31:0]) : q[31:0];
    end

endmodule

@@ sv/matrix3x3_inverse.sv @@
// Pipeline: 8 cofactor/determinant stages, 34 divider stages (each after the first
// yields one quotient bit), then one output register.
// Throughput: one matrix per cycle while the output is not stalled; nine divider lanes run side by side.
// Output stall freezes the whole pipeline.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module matrix3x3_inverse #(
    parameter int unsigned FRAC_BITS = mi3_pkg::DEF_FRAC
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,  // in_r0c0 .. in_r2c2, 32 bits each
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,  // out_r0c0 .. out_r2c2, det_value, 32 bits each
    output logic [1:0]   m_tuser   // singular, saturated
);
    localparam int unsigned N    = mi3_pkg::N_ELEM;
    localparam int unsigned DW   = mi3_pkg::DET_W;
    localparam int unsigned MW   = mi3_pkg::DMAG_W;
    localparam int unsigned QB   = mi3_pkg::Q_BITS;
    localparam int unsigned LAST = mi3_pkg::LAST_ST;
    localparam int unsigned DS   = mi3_pkg::FRONT_LAT + 1;

    logic ce;
    logic vld_reg [1:LAST];
    logic out_vld_reg;

    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_vld_reg;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    logic signed [31:0] mat_pipe [1:LAST][N];
    logic signed [63:0] p0_reg [N];
    logic signed [63:0] p1_reg [N];
    logic signed [64:0] adj_reg [N];
    logic [63:0]        am_p [4:8][N];
    logic               an_p [4:8][N];
    logic [63:0]        pl_reg [3];
    logic [63:0]        ph_reg [3];
    logic               sg_reg [3];
    logic signed [DW-1:0] sc_reg [3];
    logic signed [DW-1:0] det_reg;
    logic [MW-1:0]      dmag_reg;
    logic               dneg_reg;
    logic               dz_reg;
    logic [MW-1:0]      dp [QB];
    logic               dz_p [DS:LAST];
    logic [31:0]        detv_p [DS:LAST];
    logic               detc_p [DS:LAST];

    logic [MW-1:0] dsh;
    logic          dclip;
    assign dsh   = dmag_reg >> (2 * FRAC_BITS);
    assign dclip = dneg_reg ? (dsh > MW'(33'h1_0000_0000 >> 1))
                            : (dsh > MW'(32'h7FFF_FFFF));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < N; k++)
            begin
                mat_pipe[1][k] <= s_tdata[k*32 +: 32];
                p0_reg[k]  <= mat_pipe[1][mi3_pkg::ADJ_IDX[k][0]]
                            * mat_pipe[1][mi3_pkg::ADJ_IDX[k][1]];
                p1_reg[k]  <= mat_pipe[1][mi3_pkg::ADJ_IDX[k][2]]
                            * mat_pipe[1][mi3_pkg::ADJ_IDX[k][3]];
                adj_reg[k] <= {p0_reg[k][63], p0_reg[k]} - {p1_reg[k][63], p1_reg[k]};
                am_p[4][k] <= adj_reg[k][64] ? 64'(-adj_reg[k]) : adj_reg[k][63:0];
                an_p[4][k] <= adj_reg[k][64];
                for (int s = 5; s <= 8; s++)
                begin
                    am_p[s][k] <= am_p[s-1][k];
                    an_p[s][k] <= an_p[s-1][k];
                end
            end
            for (int s = 2; s <= LAST; s++)
                mat_pipe[s] <= mat_pipe[s-1];
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= am_p[4][j*3][31:0]  * abs32(mat_pipe[4][j]);
                ph_reg[j] <= am_p[4][j*3][63:32] * abs32(mat_pipe[4][j]);
                sg_reg[j] <= an_p[4][j*3] ^ mat_pipe[4][j][31];
                sc_reg[j] <= sg_reg[j]
                    ? -$signed({3'b000, {ph_reg[j], 32'd0} + {32'd0, pl_reg[j]}})
                    :  $signed({3'b000, {ph_reg[j], 32'd0} + {32'd0, pl_reg[j]}});
            end
            det_reg  <= sc_reg[0] + sc_reg[1] + sc_reg[2];
            dneg_reg <= det_reg[DW-1];
            dmag_reg <= det_reg[DW-1] ? MW'(-det_reg) : det_reg[MW-1:0];
            dz_reg   <= det_reg == '0;
            dp[0]       <= dmag_reg;
            dz_p[DS]    <= dz_reg;
            detc_p[DS]  <= dclip;
            detv_p[DS]  <= dclip ? (dneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                 : (dneg_reg ? (32'd0 - dsh[31:0]) : dsh[31:0]);
            for (int s = 1; s < QB; s++)
                dp[s] <= dp[s-1];
            for (int s = DS + 1; s <= LAST; s++)
            begin
                dz_p[s]   <= dz_p[s-1];
                detc_p[s] <= detc_p[s-1];
                detv_p[s] <= detv_p[s-1];
            end
        end
    end

    mi3_pkg::lane_res_t lane_res [N];

    for (genvar k = 0; k < N; k++)
    begin : g_lane
        mi3_div_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .ce    (ce),
            .amag  (am_p[8][k]),
            .aneg  (an_p[8][k] ^ dneg_reg),
            .dmag  (dmag_reg),
            .dstep (dp),
            .res   (lane_res[k])
        );
    end

    logic [319:0] out_data_reg;
    logic [1:0]   out_user_reg;
    logic [319:0] merge_data;
    logic [1:0]   merge_user;

    always_comb
    begin
        merge_user = 2'b00;
        if (dz_p[LAST])
        begin
            for (int k = 0; k < N; k++)
                merge_data[k*32 +: 32] = mat_pipe[LAST][k];
            merge_data[N*32 +: 32] = '0;
            merge_user[0] = 1'b1;
        end
        else
        begin
            merge_user[1] = detc_p[LAST];
            for (int k = 0; k < N; k++)
            begin
                merge_data[k*32 +: 32] = lane_res[k].value;
                merge_user[1] = merge_user[1] | lane_res[k].clip;
            end
            merge_data[N*32 +: 32] = detv_p[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= merge_data;
            out_user_reg <= merge_user;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            for (int s = 1; s <= LAST; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg[1] <= s_tvalid;
            for (int s = 2; s <= LAST; s++)
                vld_reg[s] <= vld_reg[s-1];
            out_vld_reg <= vld_reg[LAST];
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

@@ sv/mi3_checker.sv @@
module mi3_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [319:0] m_tdata,
    input logic [1:0]   m_tuser
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[319:288] == 32'd0)
        else $error("singular result with nonzero determinant");

    a_sing_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("singular result flagged saturated");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int unsigned FB       = mi3_pkg::DEF_FRAC;
    localparam int unsigned N_RAND   = 1000;
    localparam int unsigned IDLE_LIM = 5000;

    typedef logic signed [31:0] elem_t;
    typedef elem_t mat_t [9];

    typedef struct {
        logic [319:0] data;
        logic [1:0]   flags;
    } inv_res_t;

    typedef struct {
        mat_t       m;
        logic       chk;
        logic [319:0] data;
        logic [1:0]   flags;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic [1:0]   m_tuser;

    inv_res_t inv_q [$];
    int       fails;
    int       idle_cnt;
    bit       sink_free;
    bit       sink_hold;
    bit       sending;

    matrix3x3_inverse uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] clip32(input logic signed [255:0] v, inout logic sat);
        if (v > 256'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -256'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic inv_res_t invert(input mat_t m);
        logic signed [255:0] e [9];
        logic signed [255:0] adj [9];
        logic signed [255:0] det, num, q;
        inv_res_t r;
        logic sat;
        sat = 1'b0;
        for (int k = 0; k < 9; k++)
            e[k] = m[k];
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = adj[0]*e[0] + adj[3]*e[1] + adj[6]*e[2];
        if (det == 0)
        begin
            for (int k = 0; k < 9; k++)
                r.data[32*k +: 32] = m[k];
            r.data[319:288] = '0;
            r.flags = 2'b01;
            return r;
        end
        for (int k = 0; k < 9; k++)
        begin
            num = adj[k] <<< (2*FB);
            q = num / det;
            r.data[32*k +: 32] = clip32(q, sat);
        end
        q = det / (256'sd1 <<< (2*FB));
        r.data[319:288] = clip32(q, sat);
        r.flags = {sat, 1'b0};
        return r;
    endfunction

    function automatic mat_t rand_mat();
        mat_t m;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
        begin
            case (mode)
                0, 1, 2: m[k] = $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
                3:       m[k] = $urandom();
                4:       m[k] = $signed($urandom_range(0, 12)) - 6;
                5:       m[k] = ($signed($urandom_range(0, 8)) - 4) <<< FB;
                default: m[k] = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            endcase
        end
        if (mode == 6)
            for (int k = 0; k < 3; k++)
                m[6+k] = m[k] + m[3+k];
        if (mode == 7)
            m[$urandom_range(0, 8)] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return m;
    endfunction

    task automatic send(input mat_t m);
        logic [287:0] d;
        for (int k = 0; k < 9; k++)
            d[32*k +: 32] = m[k];
        while ($urandom_range(0, 99) < 38 && !sink_free)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        inv_q.push_back(invert(m));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic mat_t diag(input elem_t a, input elem_t b, input elem_t c);
        mat_t m;
        foreach (m[k])
            m[k] = 0;
        m[0] = a;
        m[4] = b;
        m[8] = c;
        return m;
    endfunction

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (inv_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, got %h %b", $time, m_tdata, m_tuser);
                fails++;
            end
            else
            begin
                inv_res_t x;
                x = inv_q.pop_front();
                for (int k = 0; k < 10; k++)
                    if (x.data[32*k +: 32] !== m_tdata[32*k +: 32])
                    begin
                        $display("%0t: field %0d expected %h actual %h", $time, k,
                                 x.data[32*k +: 32], m_tdata[32*k +: 32]);
                        fails++;
                    end
                if (x.flags !== m_tuser)
                begin
                    $display("%0t: flags expected %b actual %b", $time, x.flags, m_tuser);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIM)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else
            m_tready <= sink_free || ($urandom_range(0, 99) >= 38);
    end

    initial
    begin
        row_t dir [$];
        row_t r;
        mat_t m;
        fails     = 0;
        idle_cnt  = 0;
        sink_free = 0;
        sink_hold = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, hand-checked
        r.m = diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        r.chk = 1;
        r.data = {32'h0001_0000, 32'h0001_0000, 96'h0, 32'h0001_0000, 96'h0, 32'h0001_0000};
        r.flags = 2'b00;
        dir.push_back(r);
        // all zero: singular pass-through
        r.m = diag(0, 0, 0);
        r.data = '0;
        r.flags = 2'b01;
        dir.push_back(r);
        // all max: singular pass-through
        foreach (r.m[k])
            r.m[k] = 32'sh7FFF_FFFF;
        r.data = {32'h0, {9{32'h7FFF_FFFF}}};
        dir.push_back(r);
        foreach (r.m[k])
            r.m[k] = 32'sh8000_0000;
        r.data = {32'h0, {9{32'h8000_0000}}};
        dir.push_back(r);
        r.chk = 0;
        dir.push_back('{diag(1, 1, 1), 0, '0, '0});
        dir.push_back('{diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0, '0, '0});
        dir.push_back('{diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 0, '0, '0});
        dir.push_back('{diag(32'sh8000_0000, 32'sh7FFF_FFFF, -1), 0, '0, '0});
        dir.push_back('{diag(-32'sh2_0000, 32'sh4_0000, 32'sh8000), 0, '0, '0});
        dir.push_back('{diag(32'sh7FFF_FFFF, 1, 32'sh8000_0000), 0, '0, '0});
        dir.push_back('{diag(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678), 0, '0, '0});
        m = diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
        m[1] = 32'sh7FFF_FFFF;
        m[5] = 32'sh8000_0000;
        dir.push_back('{m, 0, '0, '0});

        foreach (dir[i])
        begin
            send(dir[i].m);
            if (dir[i].chk)
            begin
                inv_q[$].data  = dir[i].data;
                inv_q[$].flags = dir[i].flags;
            end
        end

        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == 200)
                sink_hold = 1;
            if (n == 400)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (inv_q.size() != 0)
                    @(posedge clk);
            end
            sink_free = (n >= 500 && n < 650);
            send(rand_mat());
        end
        sink_free = 0;
        s_tvalid <= 1'b0;

        while (inv_q.size() != 0)
            @(posedge clk);
        repeat (mi3_pkg::LAST_ST + 10) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        wait (sink_hold);
        repeat (300) @(posedge clk);
        sink_hold = 0;
    end
endmodule
